@@ rtl/assert_macros.svh @@
// assertion helper macros for the intel hex record parser rtl
// clocked on clk, disabled while rst_n is low; empty bodies when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/ihex_pkg.sv @@
// shared types, codes and the hex digit decoder for the intel hex record parser
// no dependencies
package ihex_pkg;

  typedef enum logic [4:0] {
    PH_LINE_START = 5'b00001,
    PH_SKIP       = 5'b00010,
    PH_HEADER     = 5'b00100,
    PH_DATA       = 5'b01000,
    PH_CHECK      = 5'b10000
  } phase_t;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAIL  = 2'd2;

  localparam logic [2:0] ERR_HEADER        = 3'd0;
  localparam logic [2:0] ERR_RANGE         = 3'd1;
  localparam logic [2:0] ERR_DATA          = 3'd2;
  localparam logic [2:0] ERR_CHECK_MISSING = 3'd3;
  localparam logic [2:0] ERR_CHECK_BAD     = 3'd4;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.val = 4'(c - 8'h57);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

@@ rtl/intel_hex_record_parser_unit.sv @@
// intel hex record parser: one text character per transaction in, data byte writes
// and a finish or failure transaction out; uses ihex_pkg and assert_macros.svh
//
//  channel | dir | tdata                      | tuser       | tlast
//  in_     | in  | text_char                  | -           | end_of_text
//  out_    | out | write_address, write_byte, | result_kind | -
//          |     | error_code, pages_used     |             |
//
// one character a cycle while in_tready is high; a result is in the output register the cycle after acceptance.
// the parse state updates at acceptance; the output register holds at most one result.
// in_tready drops only while a result waits and out_tready is low.
// reset clears the phase, digit counter, page bitmap, page count, stop flag and output valid.
// after a finish or failure every character is accepted and dropped until reset.
`include "assert_macros.svh"

module intel_hex_record_parser_unit import ihex_pkg::*; #(
  parameter int FLASH_BYTES = 8192,
  parameter int PAGE_BYTES  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_char
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [12:0] write_address, [20:13] write_byte,
                                  // [23:21] error_code, [31:24] pages_used
  output logic [1:0]  out_tuser   // [1:0] result_kind
);

  // page size must be a power of two (the block does not check it), so the page number is a shift
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int NPAGES     = (FLASH_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int PIDX_W     = (NPAGES > 1) ? $clog2(NPAGES) : 1;
  localparam logic [16:0] FLASH_LIMIT = 17'(FLASH_BYTES);

  phase_t            phase_r, phase_nxt;
  logic              stopped_r, stopped_nxt;
  logic [3:0]        nibble_r, nibble_nxt;
  logic [2:0]        digit_r, digit_nxt;
  logic [7:0]        rec_len_r, rec_len_nxt;
  logic [15:0]       rec_addr_r, rec_addr_nxt;
  logic [7:0]        rec_kind_r, rec_kind_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        data_idx_r, data_idx_nxt;
  logic [NPAGES-1:0] page_marks_r, page_marks_nxt;
  logic [7:0]        page_count_r, page_count_nxt;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [31:0]       out_data_r;

  logic              in_accept;
  logic              emit_c;
  logic [1:0]        kind_c;
  logic [12:0]       waddr_c;
  logic [7:0]        wbyte_c;
  logic [2:0]        err_c;
  logic [7:0]        pages_c;
  hex_digit_t        hd;
  logic [7:0]        byte_c;
  logic [16:0]       addr_sum;
  logic [16:0]       range_sum;
  logic [16:0]       page_sum;
  logic [PIDX_W-1:0] page_idx;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign hd        = hex_decode(in_tdata);
  assign byte_c    = {nibble_r, hd.val};
  assign addr_sum  = {1'b0, rec_addr_r} + {9'b0, data_idx_r};
  assign page_sum  = addr_sum >> PAGE_SHIFT;
  assign page_idx  = page_sum[PIDX_W-1:0];
  assign range_sum = {1'b0, rec_addr_nxt} + {9'b0, rec_len_nxt};

  always_comb begin
    phase_nxt      = phase_r;
    stopped_nxt    = stopped_r;
    nibble_nxt     = nibble_r;
    digit_nxt      = digit_r;
    rec_len_nxt    = rec_len_r;
    rec_addr_nxt   = rec_addr_r;
    rec_kind_nxt   = rec_kind_r;
    sum_nxt        = sum_r;
    data_idx_nxt   = data_idx_r;
    page_marks_nxt = page_marks_r;
    page_count_nxt = page_count_r;
    emit_c         = 1'b0;
    kind_c         = KIND_WRITE;
    waddr_c        = 13'd0;
    wbyte_c        = 8'd0;
    err_c          = ERR_HEADER;
    pages_c        = 8'd0;

    if (in_accept && !stopped_r) begin
      unique case (phase_r)
        PH_LINE_START: begin
          if (in_tdata == CHAR_COLON) begin
            phase_nxt    = PH_HEADER;
            digit_nxt    = 3'd0;
            rec_len_nxt  = 8'd0;
            rec_addr_nxt = 16'd0;
            rec_kind_nxt = 8'd0;
          end else if (in_tdata != CHAR_NEWLINE) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (in_tdata == CHAR_NEWLINE) begin
            phase_nxt = PH_LINE_START;
          end
        end
        PH_HEADER: begin
          if (!hd.ok) begin
            emit_c      = 1'b1;
            kind_c      = KIND_FAIL;
            err_c       = ERR_HEADER;
            stopped_nxt = 1'b1;
          end else begin
            if (digit_r < 3'd2) begin
              rec_len_nxt = {rec_len_r[3:0], hd.val};
            end else if (digit_r < 3'd6) begin
              rec_addr_nxt = {rec_addr_r[11:0], hd.val};
            end else begin
              rec_kind_nxt = {rec_kind_r[3:0], hd.val};
            end
            if (digit_r != 3'd7) begin
              digit_nxt = digit_r + 3'd1;
            end else begin
              digit_nxt = 3'd0;
              if (rec_kind_nxt == REC_EOF) begin
                emit_c      = 1'b1;
                kind_c      = KIND_DONE;
                pages_c     = page_count_r;
                stopped_nxt = 1'b1;
              end else if (rec_kind_nxt != REC_DATA) begin
                phase_nxt = PH_SKIP;
              end else if (range_sum > FLASH_LIMIT) begin
                emit_c      = 1'b1;
                kind_c      = KIND_FAIL;
                err_c       = ERR_RANGE;
                stopped_nxt = 1'b1;
              end else begin
                sum_nxt      = rec_len_nxt + rec_addr_nxt[15:8] + rec_addr_nxt[7:0];
                data_idx_nxt = 8'd0;
                phase_nxt    = (rec_len_nxt != 8'd0) ? PH_DATA : PH_CHECK;
              end
            end
          end
        end
        PH_DATA: begin
          if (!hd.ok) begin
            emit_c      = 1'b1;
            kind_c      = KIND_FAIL;
            err_c       = ERR_DATA;
            stopped_nxt = 1'b1;
          end else if (digit_r == 3'd0) begin
            nibble_nxt = hd.val;
            digit_nxt  = 3'd1;
          end else begin
            digit_nxt = 3'd0;
            sum_nxt   = sum_r + byte_c;
            if (!page_marks_r[page_idx]) begin
              page_marks_nxt[page_idx] = 1'b1;
              if (page_count_r != COUNT_MAX) begin
                page_count_nxt = page_count_r + 8'd1;
              end
            end
            emit_c       = 1'b1;
            kind_c       = KIND_WRITE;
            waddr_c      = addr_sum[12:0];
            wbyte_c      = byte_c;
            data_idx_nxt = data_idx_r + 8'd1;
            if (data_idx_nxt >= rec_len_r) begin
              phase_nxt = PH_CHECK;
            end
          end
        end
        PH_CHECK: begin
          if (!hd.ok) begin
            emit_c      = 1'b1;
            kind_c      = KIND_FAIL;
            err_c       = ERR_CHECK_MISSING;
            stopped_nxt = 1'b1;
          end else if (digit_r == 3'd0) begin
            nibble_nxt = hd.val;
            digit_nxt  = 3'd1;
          end else begin
            digit_nxt = 3'd0;
            if (8'(sum_r + byte_c) != 8'h00) begin
              emit_c      = 1'b1;
              kind_c      = KIND_FAIL;
              err_c       = ERR_CHECK_BAD;
              stopped_nxt = 1'b1;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        default: phase_nxt = PH_SKIP;
      endcase

      // end of text overrides any data write from the same character
      if (in_tlast && !stopped_nxt) begin
        emit_c      = 1'b1;
        stopped_nxt = 1'b1;
        waddr_c     = 13'd0;
        wbyte_c     = 8'd0;
        pages_c     = 8'd0;
        err_c       = ERR_HEADER;
        if (phase_nxt == PH_HEADER) begin
          kind_c = KIND_FAIL;
          err_c  = ERR_HEADER;
        end else if (phase_nxt == PH_DATA) begin
          kind_c = KIND_FAIL;
          err_c  = ERR_DATA;
        end else if (phase_nxt == PH_CHECK) begin
          kind_c = KIND_FAIL;
          err_c  = ERR_CHECK_MISSING;
        end else begin
          kind_c  = KIND_DONE;
          pages_c = page_count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LINE_START;
      stopped_r    <= 1'b0;
      digit_r      <= 3'd0;
      page_marks_r <= '0;
      page_count_r <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      stopped_r    <= stopped_nxt;
      digit_r      <= digit_nxt;
      page_marks_r <= page_marks_nxt;
      page_count_r <= page_count_nxt;
      if (in_accept) begin
        out_valid_r <= emit_c;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    nibble_r   <= nibble_nxt;
    rec_len_r  <= rec_len_nxt;
    rec_addr_r <= rec_addr_nxt;
    rec_kind_r <= rec_kind_nxt;
    sum_r      <= sum_nxt;
    data_idx_r <= data_idx_nxt;
    if (in_accept && emit_c) begin
      out_kind_r <= kind_c;
      out_data_r <= {pages_c, err_c, wbyte_c, waddr_c};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

  `ASSERT_CLK(a_stop_sticks, stopped_r |=> stopped_r, "stop flag cleared without reset")
  `ASSERT_CLK(a_end_result_stops,
    (in_accept && emit_c && kind_c != KIND_WRITE) |=> stopped_r,
    "finish or failure transaction did not stop the parser")
  `ASSERT_CLK(a_page_count_tracks,
    ($countones(page_marks_r) < 255) |-> (32'(page_count_r) == $countones(page_marks_r)),
    "page count differs from marked pages")
  `ASSERT_NEVER(a_data_index_bound,
    (phase_r == PH_DATA) && (data_idx_r >= rec_len_r),
    "data phase with no bytes left in the record")
  `ASSERT_NEVER(a_byte_digit_bound,
    ((phase_r == PH_DATA) || (phase_r == PH_CHECK)) && (digit_r > 3'd1),
    "digit counter out of range for a byte")

endmodule
